// ----- sv/int_to_ascii_fixed_width_assert.svh -----
// Assertion macros used by the top-level RTL file of the converter.
// Both macros sample on the rising clock and are switched off while reset is held.
`ifndef INT_TO_ASCII_FIXED_WIDTH_ASSERT_SVH
`define INT_TO_ASCII_FIXED_WIDTH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITOAFW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITOAFW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/itoafw_pkg.sv -----
package itoafw_pkg;

  localparam int VALUE_W     = 32;
  localparam int DIGIT_W     = 4;
  localparam int CHAR_W      = 7;
  localparam int COUNT_CFG_W = 5;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 5;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;

  localparam int MAX_DIGITS_DEF = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_RADIX_HEX   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_DIGIT_COUNT = 1'b1;

  localparam logic                   RADIX_HEX_RST   = 1'b1;
  localparam logic [COUNT_CFG_W-1:0] DIGIT_COUNT_RST = 5'd8;

  // Multiplying by this constant and dropping RECIP10_SHIFT bits divides any
  // 32-bit unsigned value by ten exactly.
  localparam logic [VALUE_W-1:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int                 RECIP10_SHIFT = 35;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_A_BIAS = 7'd87;
  localparam logic [DIGIT_W-1:0] DEC_BASE   = 4'd10;

  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = CHAR_W'(d);
    if (d < DEC_BASE) begin
      digit_glyph = CHAR_ZERO + d_ext;
    end else begin
      digit_glyph = CHAR_A_BIAS + d_ext;
    end
  endfunction

endpackage

// ----- sv/int_to_ascii_fixed_width.sv -----
// Converts each 32-bit unsigned value into W ASCII digit characters, most
// significant first, in lower-case hexadecimal or in decimal as the radix
// register selects; W is the digit_count register clamped to MAX_DIGITS, and
// a count of zero makes the value produce no characters. Leading positions are
// zero-padded and digits that do not fit are dropped, except that a hex zero
// comes out as the single character '0'. The last character of each value has
// tlast set. One shared unit (a 32x32 reciprocal multiply for decimal, a shift
// for hex) yields one digit per cycle into a small digit memory; then each
// character is read from the memory and offered as one output transaction.
// No new value is accepted until the last character of a value is taken.
// Configuration must be written only while the block is idle.
`include "int_to_ascii_fixed_width_assert.svh"

module int_to_ascii_fixed_width
  import itoafw_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
)(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [6:0] digit_char, [7] zero fill
  output logic                   out_tlast
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_RD, S_OUT} state_t;

  state_t             state_r, state_nxt;
  logic               radix_hex_r, radix_hex_nxt;
  logic [COUNT_CFG_W-1:0] digit_count_r, digit_count_nxt;
  logic [CNT_W-1:0]   width_r, width_nxt;
  logic [IDX_W-1:0]   conv_idx_r, conv_idx_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_accept;
  logic [VALUE_W-1:0] in_value;
  logic [CNT_W-1:0]   width_clamped;
  logic               conv_last;
  logic               unit_start;
  logic [VALUE_W-1:0] unit_operand;
  logic [VALUE_W-1:0] unit_quot;
  logic [DIGIT_W-1:0] unit_digit;
  logic               store_wr_en;
  logic               store_rd_en;
  logic [DIGIT_W-1:0] store_rd_data;

  assign in_value  = in_tdata[VALUE_W-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;

  assign width_clamped = (32'(digit_count_r) > 32'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
                                                                : CNT_W'(digit_count_r);
  assign conv_last = (CNT_W'(conv_idx_r) == (width_r - CNT_W'(1)));

  assign unit_start   = (in_accept && (width_clamped != '0))
                     || ((state_r == S_CONV) && !conv_last);
  assign unit_operand = (state_r == S_IDLE) ? in_value : unit_quot;
  assign store_wr_en  = (state_r == S_CONV);
  assign store_rd_en  = (state_r == S_RD);

  itoafw_digit_unit u_unit (
    .clk     (clk),
    .start   (unit_start),
    .hex     (radix_hex_r),
    .operand (unit_operand),
    .quot    (unit_quot),
    .digit   (unit_digit)
  );

  itoafw_digit_store #(
    .DEPTH (MAX_DIGITS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr_en),
    .wr_idx  (conv_idx_r),
    .wr_data (unit_digit),
    .rd_en   (store_rd_en),
    .rd_idx  (rd_idx_r),
    .rd_data (store_rd_data)
  );

  always_comb begin
    state_nxt       = state_r;
    radix_hex_nxt   = radix_hex_r;
    digit_count_nxt = digit_count_r;
    width_nxt       = width_r;
    conv_idx_nxt    = conv_idx_r;
    rd_idx_nxt      = rd_idx_r;
    out_valid_nxt   = out_valid_r;
    out_last_nxt    = out_last_r;

    if (cfg_wr_en) begin
      case (cfg_addr)
        REG_RADIX_HEX:   radix_hex_nxt   = cfg_wdata[0];
        REG_DIGIT_COUNT: digit_count_nxt = cfg_wdata[COUNT_CFG_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept && (width_clamped != '0)) begin
          // A hex zero converts as one digit so that only a single '0' comes out.
          width_nxt    = (radix_hex_r && (in_value == '0)) ? CNT_W'(1) : width_clamped;
          conv_idx_nxt = '0;
          state_nxt    = S_CONV;
        end
      end
      S_CONV: begin
        if (conv_last) begin
          rd_idx_nxt = IDX_W'(width_r - CNT_W'(1));
          state_nxt  = S_RD;
        end else begin
          conv_idx_nxt = conv_idx_r + IDX_W'(1);
        end
      end
      S_RD: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = (rd_idx_r == '0);
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r - IDX_W'(1);
            state_nxt  = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      radix_hex_r   <= RADIX_HEX_RST;
      digit_count_r <= DIGIT_COUNT_RST;
      width_r       <= '0;
      conv_idx_r    <= '0;
      rd_idx_r      <= '0;
      out_valid_r   <= 1'b0;
      out_last_r    <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      radix_hex_r   <= radix_hex_nxt;
      digit_count_r <= digit_count_nxt;
      width_r       <= width_nxt;
      conv_idx_r    <= conv_idx_nxt;
      rd_idx_r      <= rd_idx_nxt;
      out_valid_r   <= out_valid_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_TDATA_W'(digit_glyph(store_rd_data));

  `ITOAFW_ASSERT_SAME(a_no_accept_while_emitting, 1'b1, !(in_tready && out_tvalid), "input accepted while a character is pending")
  `ITOAFW_ASSERT_NEXT(a_idle_after_last, out_tvalid && out_tready && out_tlast, in_tready, "block not idle after the last character of a value")
  `ITOAFW_ASSERT_SAME(a_conv_in_range, state_r == S_CONV, CNT_W'(conv_idx_r) < width_r, "digit index ran past the width")
  `ITOAFW_ASSERT_SAME(a_rd_in_range, (state_r == S_RD) || (state_r == S_OUT), CNT_W'(rd_idx_r) < width_r, "read index outside the converted digits")

endmodule

// ----- sv/itoafw_digit_unit.sv -----
module itoafw_digit_unit
  import itoafw_pkg::*;
(
  input  logic               clk,
  input  logic               start,
  input  logic               hex,
  input  logic [VALUE_W-1:0] operand,
  output logic [VALUE_W-1:0] quot,
  output logic [DIGIT_W-1:0] digit
);

  logic [VALUE_W-1:0]   operand_r;
  logic                 hex_r;
  logic [2*VALUE_W-1:0] prod_r;
  logic [DIGIT_W-1:0]   q_low;
  logic [DIGIT_W-1:0]   dec_digit;

  always_ff @(posedge clk) begin
    if (start) begin
      operand_r <= operand;
      hex_r     <= hex;
      prod_r    <= (2*VALUE_W)'(operand) * (2*VALUE_W)'(RECIP10);
    end
  end

  // The decimal remainder is below ten, so the low four bits of
  // operand - 10 * quotient are enough to recover it.
  assign q_low     = prod_r[RECIP10_SHIFT +: DIGIT_W];
  assign dec_digit = operand_r[DIGIT_W-1:0] - {q_low[0], 3'b000} - {q_low[2:0], 1'b0};

  assign quot  = hex_r ? (operand_r >> DIGIT_W)
                       : VALUE_W'(prod_r[2*VALUE_W-1:RECIP10_SHIFT]);
  assign digit = hex_r ? operand_r[DIGIT_W-1:0] : dec_digit;

endmodule

// ----- sv/itoafw_digit_store.sv -----
module itoafw_digit_store
  import itoafw_pkg::*;
#(
  parameter int DEPTH = MAX_DIGITS_DEF,
  parameter int IDX_W = 4
)(
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_idx,
  input  logic [DIGIT_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_idx,
  output logic [DIGIT_W-1:0] rd_data
);

  logic [DIGIT_W-1:0] mem [DEPTH];
  logic [DIGIT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- test/tb_int_to_ascii_fixed_width.sv -----
`timescale 1ns / 100ps

module tb_int_to_ascii_fixed_width;
  import itoafw_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] glyph;
    logic              last;
  } char_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [31:0] value
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [6:0] digit_char, [7] zero fill
  logic                   out_tlast;

  logic                   model_hex;
  logic [COUNT_CFG_W-1:0] model_count;
  logic [VALUE_W-1:0]     value_q[$];
  char_t                  char_q[$];
  int                     send_idle_pct;
  int                     recv_idle_pct;
  int                     error_count = 0;
  int                     values_sent = 0;
  int                     chars_checked = 0;
  int                     formats_used = 0;

  int_to_ascii_fixed_width DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic void predict_chars(logic [VALUE_W-1:0] value);
    int                 width;
    logic [VALUE_W-1:0] rest;
    logic [3:0]         digits [16];
    logic [3:0]         d;
    char_t              c;
    width = (model_count > 16) ? 16 : int'(model_count);
    if (width == 0) return;
    if (model_hex && value == '0) begin
      c.glyph = 7'h30;
      c.last = 1'b1;
      char_q.push_back(c);
      return;
    end
    rest = value;
    for (int i = 0; i < width; i++) begin
      if (model_hex) begin
        digits[i] = rest[3:0];
        rest = rest >> 4;
      end else begin
        digits[i] = 4'(rest % 10);
        rest = rest / 10;
      end
    end
    for (int k = 0; k < width; k++) begin
      d = digits[width - 1 - k];
      c.glyph = (d < 4'd10) ? (7'h30 + 7'(d)) : (7'h57 + 7'(d));
      c.last = (k == width - 1);
      char_q.push_back(c);
    end
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return $urandom_range(99);
      1: return '0;
      2: return 32'hFFFF_FFFF - $urandom_range(15);
      3: return 32'(1) << $urandom_range(31);
      4: return $urandom_range(9999999);
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_chars(in_tdata);
        values_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (value_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= value_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (char_q.size() == 0) begin
        $display("%0t: unexpected character, expected none, actual %0h last %0b",
                 $time, out_tdata, out_tlast);
        error_count++;
      end else begin
        want = char_q.pop_front();
        chars_checked++;
        if (out_tdata[CHAR_W-1:0] !== want.glyph) begin
          $display("%0t: digit_char mismatch, expected %0h, actual %0h",
                   $time, want.glyph, out_tdata[CHAR_W-1:0]);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last mismatch, expected %0b, actual %0b",
                   $time, want.last, out_tlast);
          error_count++;
        end
        if (out_tdata[OUT_TDATA_W-1:CHAR_W] !== '0) begin
          $display("%0t: fill bits mismatch, expected 0, actual %0b",
                   $time, out_tdata[OUT_TDATA_W-1:CHAR_W]);
          error_count++;
        end
      end
    end
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (addr == REG_RADIX_HEX) begin
      model_hex = data[0];
    end else begin
      model_count = data;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (value_q.size() != 0 || in_tvalid || char_q.size() != 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_format(logic hex, logic [COUNT_CFG_W-1:0] count);
    wait_idle();
    write_reg(REG_RADIX_HEX, {4'($urandom_range(15)), hex});
    write_reg(REG_DIGIT_COUNT, count);
    formats_used++;
    @(negedge clk);
  endtask

  initial begin
    int                     pick;
    logic [COUNT_CFG_W-1:0] count;
    model_hex = RADIX_HEX_RST;
    model_count = DIGIT_COUNT_RST;
    send_idle_pct = 38;
    recv_idle_pct = 45;
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    formats_used = 1;
    value_q.push_back(32'h0000_0000);
    value_q.push_back(32'h0000_0001);
    value_q.push_back(32'hFFFF_FFFF);
    value_q.push_back(32'h8000_0000);
    value_q.push_back(32'h1234_5678);
    value_q.push_back(32'h9ABC_DEF0);

    set_format(1'b0, 5'd16);
    value_q.push_back(32'd0);
    value_q.push_back(32'd4294967295);
    value_q.push_back(32'd1);
    value_q.push_back(32'd1000000000);
    value_q.push_back(32'd987654321);

    set_format(1'b0, 5'd1);
    value_q.push_back(32'd0);
    value_q.push_back(32'd19);
    value_q.push_back(32'd4294967295);

    set_format(1'b1, 5'd16);
    value_q.push_back(32'hFFFF_FFFF);
    value_q.push_back(32'h0000_0000);
    value_q.push_back(32'h0000_ABCD);

    // A width of zero must swallow the value without any output.
    set_format(1'b1, 5'd0);
    value_q.push_back(32'd5);
    value_q.push_back(32'd0);

    set_format(1'b1, 5'd31);
    value_q.push_back(32'h89AB_CDEF);

    set_format(1'b0, 5'd17);
    value_q.push_back(32'd4294967295);
    value_q.push_back(32'd0);

    set_format(1'b1, 5'd1);
    value_q.push_back(32'hFEDC_BA98);
    value_q.push_back(32'h0000_0000);

    for (int chunk = 0; chunk < 12; chunk++) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        count = 5'd1;
      end else if (pick == 1) begin
        count = 5'd16;
      end else if (pick == 2) begin
        count = 5'($urandom_range(31, 17));
      end else begin
        count = 5'($urandom_range(16, 1));
      end
      set_format(1'($urandom_range(1)), count);
      case (chunk / 4)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < 35; n++) value_q.push_back(rand_value());
    end

    wait_idle();
    $display("Converted %0d values into %0d checked characters under %0d output formats,",
             values_sent, chars_checked, formats_used);
    $display("covering both radixes, widths from zero past the maximum, and three stall patterns.");
    if (error_count == 0 && char_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
